FILE: sv/blvm_pkg.sv
package blvm_pkg;

  // Width of an ADC sample and of the three threshold registers
  localparam int unsigned SampleBits = 12;
  localparam int unsigned RunBits    = 8;
  localparam int unsigned TimeBits   = 32;
  localparam int unsigned CfgIdxBits = 3;

  localparam logic [RunBits-1:0] RunMax = {RunBits{1'b1}};

  // Register defaults after reset
  localparam logic [SampleBits-1:0] CriticalLevelRst = SampleBits'(2091);
  localparam logic [SampleBits-1:0] WarnLevelRst     = SampleBits'(2146);
  localparam logic [SampleBits-1:0] RearmLevelRst    = SampleBits'(2160);
  localparam logic [RunBits-1:0]    CriticalSampRst  = RunBits'(10);
  localparam logic [RunBits-1:0]    WarnSampRst      = RunBits'(10);
  localparam logic [TimeBits-1:0]   ReminderRst      = TimeBits'(5 * 60 * 1000);

  typedef enum logic [CfgIdxBits-1:0] {
    CfgEnable        = 3'd0,
    CfgCriticalLevel = 3'd1,
    CfgWarnLevel     = 3'd2,
    CfgRearmLevel    = 3'd3,
    CfgCriticalSamp  = 3'd4,
    CfgWarnSamp      = 3'd5,
    CfgReminder      = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BandCritical  = 3'd0,
    BandLow       = 3'd1,
    BandGap       = 3'd2,
    BandRecovered = 3'd3,
    BandIgnored   = 3'd4
  } band_e;

  typedef enum logic [1:0] {
    PromptNone     = 2'd0,
    PromptFirst    = 2'd1,
    PromptReminder = 2'd2
  } prompt_e;

  typedef struct packed {
    logic                  enable;
    logic [SampleBits-1:0] critical_level;
    logic [SampleBits-1:0] warn_level;
    logic [SampleBits-1:0] rearm_level;
    logic [RunBits-1:0]    critical_samples;
    logic [RunBits-1:0]    warn_samples;
    logic [TimeBits-1:0]   reminder_ms;
  } cfg_t;

  typedef struct packed {
    logic [RunBits-1:0]  low_run;
    logic [RunBits-1:0]  critical_run;
    logic                warned;
    logic [TimeBits-1:0] last_prompt_ms;
  } state_t;

  typedef struct packed {
    logic [SampleBits-1:0] sample;
    logic                  sample_ok;
    logic [TimeBits-1:0]   now_ms;
  } item_t;

  typedef struct packed {
    prompt_e prompt;
    logic    power_off;
    band_e   band;
    logic    warned;
  } result_t;

endpackage

FILE: sv/blvm_cfg_regs.sv
module blvm_cfg_regs
  import blvm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [TimeBits-1:0]   cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the register index and merge the write word
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgEnable:        cfg_d.enable           = cfg_data_i[0];
        CfgCriticalLevel: cfg_d.critical_level   = cfg_data_i[SampleBits-1:0];
        CfgWarnLevel:     cfg_d.warn_level       = cfg_data_i[SampleBits-1:0];
        CfgRearmLevel:    cfg_d.rearm_level      = cfg_data_i[SampleBits-1:0];
        CfgCriticalSamp:  cfg_d.critical_samples = cfg_data_i[RunBits-1:0];
        CfgWarnSamp:      cfg_d.warn_samples     = cfg_data_i[RunBits-1:0];
        CfgReminder:      cfg_d.reminder_ms      = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable           <= 1'b0;
      cfg_q.critical_level   <= CriticalLevelRst;
      cfg_q.warn_level       <= WarnLevelRst;
      cfg_q.rearm_level      <= RearmLevelRst;
      cfg_q.critical_samples <= CriticalSampRst;
      cfg_q.warn_samples     <= WarnSampRst;
      cfg_q.reminder_ms      <= ReminderRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/blvm_step.sv
module blvm_step
  import blvm_pkg::*;
(
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  logic               crit_adv;
  logic               low_adv;
  logic [RunBits-1:0] crit_inc;
  logic [RunBits-1:0] low_inc;
  logic [TimeBits-1:0] elapsed;
  logic               reminder_due;

  // Saturating run counters and elapsed time since the last prompt
  assign crit_adv     = (state_i.critical_run != RunMax);
  assign low_adv      = (state_i.low_run != RunMax);
  assign crit_inc     = crit_adv ? state_i.critical_run + RunBits'(1) : state_i.critical_run;
  assign low_inc      = low_adv ? state_i.low_run + RunBits'(1) : state_i.low_run;
  assign elapsed      = item_i.now_ms - state_i.last_prompt_ms;
  assign reminder_due = (elapsed >= cfg_i.reminder_ms);

  // Classify the sample and update the state; order of tests decides
  always_comb begin
    state_o            = state_i;
    result_o.prompt    = PromptNone;
    result_o.power_off = 1'b0;
    result_o.band      = BandIgnored;
    if (cfg_i.enable && item_i.sample_ok) begin
      priority if (item_i.sample <= cfg_i.critical_level) begin
        result_o.band        = BandCritical;
        state_o.low_run      = '0;
        state_o.critical_run = crit_inc;
        result_o.power_off   = crit_adv && (crit_inc == cfg_i.critical_samples);
      end else if (item_i.sample <= cfg_i.warn_level) begin
        result_o.band        = BandLow;
        state_o.critical_run = '0;
        if (!state_i.warned) begin
          state_o.low_run = low_inc;
          if (low_adv && (low_inc == cfg_i.warn_samples)) begin
            result_o.prompt        = PromptFirst;
            state_o.warned         = 1'b1;
            state_o.last_prompt_ms = item_i.now_ms;
          end
        end else if (reminder_due) begin
          result_o.prompt        = PromptReminder;
          state_o.last_prompt_ms = item_i.now_ms;
        end
      end else if (item_i.sample >= cfg_i.rearm_level) begin
        result_o.band          = BandRecovered;
        state_o.low_run        = '0;
        state_o.critical_run   = '0;
        state_o.warned         = 1'b0;
        state_o.last_prompt_ms = '0;
      end else begin
        result_o.band        = BandGap;
        state_o.low_run      = '0;
        state_o.critical_run = '0;
      end
    end
    result_o.warned = state_o.warned;
  end

endmodule

FILE: sv/battery_low_voltage_monitor.sv
// Battery undervoltage monitor with hysteresis.
// Input channel: one word per ADC sample (sample_i, sample_ok_i, now_ms_i),
// taken at a rising edge with in_valid_i high and in_stall_o low.
// Output channel: one word per input word (prompt_o, power_off_o, band_o,
// warned_o), taken at a rising edge with out_valid_o high and out_stall_i low.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// cfg_ready_o is always high. Write registers only while the block is idle.
// A word accepted into the input register is shown once it moves on into the
// result register. Throughput: one word per cycle while the receiver does not
// stall; the input register and the result register are separated by the band
// compare, the run counters and one 32-bit subtract-and-compare for the reminder
// timer. When the receiver stalls, the result register holds; an empty input
// register still takes one more word before in_stall_o rises.
// Reset clears the run counters, warned latch, prompt time and both valid
// flags, and loads the register defaults with the monitor disabled.
module battery_low_voltage_monitor
  import blvm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SampleBits-1:0] sample_i,
  input  logic                  sample_ok_i,
  input  logic [TimeBits-1:0]   now_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            prompt_o,
  output logic                  power_off_o,
  output logic [2:0]            band_o,
  output logic                  warned_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [TimeBits-1:0]   cfg_data_i
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  logic    in_accept;
  logic    advance;
  state_t  state_q, state_d;
  result_t res_d, res_q;
  logic    out_valid_q;

  assign cfg_ready_o = 1'b1;

  blvm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Move the input word on when the result register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.sample    <= sample_i;
      item_q.sample_ok <= sample_ok_i;
      item_q.now_ms    <= now_ms_i;
    end
  end

  blvm_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Commit monitor state as the word passes into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign prompt_o    = res_q.prompt;
  assign power_off_o = res_q.power_off;
  assign band_o      = res_q.band;
  assign warned_o    = res_q.warned;

  // Power-off request only comes from a critical sample
  a_poff_critical: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && power_off_o |-> band_o == BandCritical)
    else $error("power-off request outside critical band");

  // Any prompt comes from a low sample and leaves the latch set
  a_prompt_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && prompt_o != PromptNone |-> band_o == BandLow && warned_o)
    else $error("prompt without low band or warned latch");

  // An ignored sample raises nothing
  a_ignored_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && band_o == BandIgnored |-> prompt_o == PromptNone && !power_off_o)
    else $error("ignored sample raised an event");

  // Empty result register never back-pressures the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

endmodule

FILE: verif/battery_low_voltage_monitor_tb.sv
`timescale 1ns / 1ps

module battery_low_voltage_monitor_tb;
  import blvm_pkg::*;

  localparam int unsigned RandItems  = 750;
  localparam int unsigned CycleLimit = 400000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [SampleBits-1:0] sample_i;
  logic                  sample_ok_i;
  logic [TimeBits-1:0]   now_ms_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [1:0]            prompt_o;
  logic                  power_off_o;
  logic [2:0]            band_o;
  logic                  warned_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i;
  logic [TimeBits-1:0]   cfg_data_i;

  battery_low_voltage_monitor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .sample_ok_i (sample_ok_i),
    .now_ms_i    (now_ms_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .prompt_o    (prompt_o),
    .power_off_o (power_off_o),
    .band_o      (band_o),
    .warned_o    (warned_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the monitor: registers and run state
  cfg_t    shadow_cfg;
  state_t  shadow_st;
  result_t pending_results[$];

  int unsigned errors;
  int unsigned processed;
  int unsigned skipped;
  int unsigned settings_used;
  int unsigned seen_power_off;
  int unsigned seen_first;
  int unsigned seen_reminder;
  bit          quiet_tail;
  result_t     head_word;

  typedef struct {
    bit                    is_cfg;
    cfg_idx_e              idx;
    logic [TimeBits-1:0]   data;
    logic [SampleBits-1:0] smp;
    logic                  ok;
    logic [TimeBits-1:0]   stamp;
    bit                    typed;
    result_t               want;
  } row_t;

  row_t directed_rows[$];

  // Advance the shadow monitor by one sample and return the word it must produce
  function automatic result_t predict_monitor(logic [SampleBits-1:0] smp, logic ok,
                                              logic [TimeBits-1:0] stamp);
    result_t r;
    r.prompt    = PromptNone;
    r.power_off = 1'b0;
    r.band      = BandIgnored;
    if (shadow_cfg.enable && ok) begin
      if (smp <= shadow_cfg.critical_level) begin
        r.band = BandCritical;
        shadow_st.low_run = '0;
        // fire only on the sample that moves the run onto its limit
        if (shadow_st.critical_run != RunMax) begin
          shadow_st.critical_run = shadow_st.critical_run + 1'b1;
          if (shadow_st.critical_run == shadow_cfg.critical_samples) r.power_off = 1'b1;
        end
      end else if (smp <= shadow_cfg.warn_level) begin
        r.band = BandLow;
        shadow_st.critical_run = '0;
        if (!shadow_st.warned) begin
          if (shadow_st.low_run != RunMax) begin
            shadow_st.low_run = shadow_st.low_run + 1'b1;
            if (shadow_st.low_run == shadow_cfg.warn_samples) begin
              r.prompt                 = PromptFirst;
              shadow_st.warned         = 1'b1;
              shadow_st.last_prompt_ms = stamp;
            end
          end
        end else if (TimeBits'(stamp - shadow_st.last_prompt_ms) >= shadow_cfg.reminder_ms) begin
          r.prompt                 = PromptReminder;
          shadow_st.last_prompt_ms = stamp;
        end
      end else if (smp >= shadow_cfg.rearm_level) begin
        r.band    = BandRecovered;
        shadow_st = '0;
      end else begin
        r.band                 = BandGap;
        shadow_st.low_run      = '0;
        shadow_st.critical_run = '0;
      end
    end
    r.warned = shadow_st.warned;
    return r;
  endfunction

  function automatic result_t word_of(prompt_e p, logic poff, band_e b, logic w);
    result_t r;
    r.prompt    = p;
    r.power_off = poff;
    r.band      = b;
    r.warned    = w;
    return r;
  endfunction

  function automatic row_t blank_row();
    row_t r;
    r = '{is_cfg: 1'b0, idx: CfgEnable, data: '0, smp: '0, ok: 1'b0, stamp: '0,
          typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic row_t cfg_row(cfg_idx_e idx, logic [TimeBits-1:0] data);
    row_t r;
    r        = blank_row();
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic row_t item_row(logic [SampleBits-1:0] smp, logic ok,
                                    logic [TimeBits-1:0] stamp);
    row_t r;
    r       = blank_row();
    r.smp   = smp;
    r.ok    = ok;
    r.stamp = stamp;
    return r;
  endfunction

  function automatic row_t typed_row(logic [SampleBits-1:0] smp, logic ok,
                                     logic [TimeBits-1:0] stamp, result_t want);
    row_t r;
    r       = item_row(smp, ok, stamp);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  // Offer one sample word, hold it while stalled, queue its expected result
  task automatic push_sample(input logic [SampleBits-1:0] smp, input logic ok,
                             input logic [TimeBits-1:0] stamp, input bit typed,
                             input result_t want);
    result_t     pred;
    int unsigned gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    sample_i    = smp;
    sample_ok_i = ok;
    now_ms_i    = stamp;
    do @(posedge clk_i); while (in_stall_o);
    if (shadow_cfg.enable && ok) processed++;
    else skipped++;
    pred = predict_monitor(smp, ok, stamp);
    pending_results.push_back(typed ? want : pred);
    @(negedge clk_i);
  endtask

  // Drop the input and wait until every pending word has come out
  task automatic settle();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Write one register; valid stays high so writes can go back to back
  task automatic write_reg(input cfg_idx_e idx, input logic [TimeBits-1:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgEnable:        shadow_cfg.enable           = value[0];
      CfgCriticalLevel: shadow_cfg.critical_level   = value[SampleBits-1:0];
      CfgWarnLevel:     shadow_cfg.warn_level       = value[SampleBits-1:0];
      CfgRearmLevel:    shadow_cfg.rearm_level      = value[SampleBits-1:0];
      CfgCriticalSamp:  shadow_cfg.critical_samples = value[RunBits-1:0];
      CfgWarnSamp:      shadow_cfg.warn_samples     = value[RunBits-1:0];
      CfgReminder:      shadow_cfg.reminder_ms      = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic field_mismatch(input string name, input logic [31:0] want,
                                input logic [31:0] got);
    errors++;
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
  endtask

  // Check each output word against the oldest pending expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected output word, expected none, got prompt %0h band %0h",
                 $time, prompt_o, band_o);
      end else begin
        head_word = pending_results.pop_front();
        if (prompt_o !== head_word.prompt)
          field_mismatch("prompt", 32'(head_word.prompt), 32'(prompt_o));
        if (power_off_o !== head_word.power_off)
          field_mismatch("power_off", 32'(head_word.power_off), 32'(power_off_o));
        if (band_o !== head_word.band)
          field_mismatch("band", 32'(head_word.band), 32'(band_o));
        if (warned_o !== head_word.warned)
          field_mismatch("warned", 32'(head_word.warned), 32'(warned_o));
        if (head_word.power_off) seen_power_off++;
        if (head_word.prompt == PromptFirst) seen_first++;
        if (head_word.prompt == PromptReminder) seen_reminder++;
      end
    end
  end

  // Stall the output in short random bursts until the quiet tail
  initial begin : stall_gen
    int unsigned burst;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        burst = $urandom_range(1, 4);
        repeat (burst) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
    end
  end

  // Bound the run
  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    bit                    cfg_open;
    int unsigned           kind;
    int unsigned           phase;
    int unsigned           phase_len;
    int unsigned           phase_done;
    int unsigned           band_pick;
    int unsigned           run_len;
    int unsigned           lim;
    int unsigned           cap;
    int                    c;
    int                    w;
    int                    r;
    int                    lo;
    int                    hi;
    logic [TimeBits-1:0]   stamp;
    logic [SampleBits-1:0] smp;
    logic                  ok;
    result_t               none;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    sample_ok_i = 1'b0;
    now_ms_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgEnable;
    cfg_data_i  = '0;
    quiet_tail  = 1'b0;
    errors      = 0;
    processed   = 0;
    skipped     = 0;
    settings_used  = 0;
    seen_power_off = 0;
    seen_first     = 0;
    seen_reminder  = 0;
    none = word_of(PromptNone, 1'b0, BandIgnored, 1'b0);

    shadow_cfg.enable           = 1'b0;
    shadow_cfg.critical_level   = CriticalLevelRst;
    shadow_cfg.warn_level       = WarnLevelRst;
    shadow_cfg.rearm_level      = RearmLevelRst;
    shadow_cfg.critical_samples = CriticalSampRst;
    shadow_cfg.warn_samples     = WarnSampRst;
    shadow_cfg.reminder_ms      = ReminderRst;
    shadow_st = '0;

    // Disabled after reset, then the default levels with short runs
    directed_rows.push_back(typed_row(12'd0, 1'b1, 32'd0, none));
    directed_rows.push_back(typed_row(12'd4095, 1'b1, 32'd7, none));
    directed_rows.push_back(cfg_row(CfgEnable, 32'd1));
    directed_rows.push_back(cfg_row(CfgCriticalSamp, 32'd2));
    directed_rows.push_back(cfg_row(CfgWarnSamp, 32'd2));
    directed_rows.push_back(cfg_row(CfgReminder, 32'd100));
    directed_rows.push_back(typed_row(12'd4095, 1'b1, 32'd10,
                                      word_of(PromptNone, 1'b0, BandRecovered, 1'b0)));
    // timeout: nothing moves
    directed_rows.push_back(typed_row(12'd0, 1'b0, 32'd20, none));
    // critical run up to its limit, then past it
    directed_rows.push_back(item_row(12'd0, 1'b1, 32'd30));
    directed_rows.push_back(item_row(12'd2091, 1'b1, 32'd40));
    directed_rows.push_back(item_row(12'd0, 1'b1, 32'd50));
    // low run to the first prompt, then a reminder on the exact interval
    directed_rows.push_back(item_row(12'd2146, 1'b1, 32'd1000));
    directed_rows.push_back(item_row(12'd2092, 1'b1, 32'd1050));
    directed_rows.push_back(item_row(12'd2100, 1'b1, 32'd1100));
    directed_rows.push_back(item_row(12'd2100, 1'b1, 32'd1150));
    // critical keeps the latch, the gap only clears runs, rearm clears all
    directed_rows.push_back(item_row(12'd0, 1'b1, 32'd1200));
    directed_rows.push_back(item_row(12'd2147, 1'b1, 32'd1300));
    directed_rows.push_back(item_row(12'd2159, 1'b1, 32'd1400));
    directed_rows.push_back(typed_row(12'd2160, 1'b1, 32'd1500,
                                      word_of(PromptNone, 1'b0, BandRecovered, 1'b0)));
    // zero interval, zero critical limit, timer wrap
    directed_rows.push_back(cfg_row(CfgWarnSamp, 32'd1));
    directed_rows.push_back(cfg_row(CfgCriticalSamp, 32'd0));
    directed_rows.push_back(cfg_row(CfgReminder, 32'd0));
    directed_rows.push_back(item_row(12'd2100, 1'b1, 32'hFFFF_FFF0));
    directed_rows.push_back(item_row(12'd2100, 1'b1, 32'd5));
    directed_rows.push_back(cfg_row(CfgReminder, 32'hFFFF_FFFF));
    directed_rows.push_back(item_row(12'd2100, 1'b1, 32'd4));
    directed_rows.push_back(item_row(12'd2100, 1'b1, 32'd5));
    directed_rows.push_back(item_row(12'd0, 1'b1, 32'd6));
    directed_rows.push_back(item_row(12'd0, 1'b1, 32'd7));
    // thresholds at the extremes, band order decides
    directed_rows.push_back(cfg_row(CfgCriticalLevel, 32'd0));
    directed_rows.push_back(cfg_row(CfgWarnLevel, 32'd0));
    directed_rows.push_back(cfg_row(CfgRearmLevel, 32'd0));
    directed_rows.push_back(item_row(12'd0, 1'b1, 32'd8));
    directed_rows.push_back(typed_row(12'd1, 1'b1, 32'd9,
                                      word_of(PromptNone, 1'b0, BandRecovered, 1'b0)));
    directed_rows.push_back(cfg_row(CfgCriticalLevel, 32'd4095));
    directed_rows.push_back(cfg_row(CfgWarnLevel, 32'd4095));
    directed_rows.push_back(cfg_row(CfgRearmLevel, 32'd4095));
    directed_rows.push_back(typed_row(12'd4095, 1'b1, 32'd10,
                                      word_of(PromptNone, 1'b0, BandCritical, 1'b0)));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Walk the directed rows; settle before each group of writes
    cfg_open = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        if (!cfg_open) settle();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_valid_i = 1'b0;
          cfg_open    = 1'b0;
          settings_used++;
        end
        push_sample(directed_rows[i].smp, directed_rows[i].ok, directed_rows[i].stamp,
                    directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases: new settings, then runs of samples aimed at one band
    stamp = $urandom;
    phase = 0;
    while (processed + skipped < RandItems) begin
      kind = phase % 5;
      case (kind)
        0, 3: begin
          c = $urandom_range(0, 4000);
          w = c + $urandom_range(1, 40);
          r = w + $urandom_range(1, 40);
        end
        1: begin
          c = 0;
          w = 4094;
          r = 4095;
        end
        default: begin
          c = $urandom_range(0, 4095);
          w = $urandom_range(0, 4095);
          r = $urandom_range(0, 4095);
        end
      endcase
      settle();
      write_reg(CfgEnable, {31'd0, kind != 4});
      write_reg(CfgCriticalLevel, c);
      write_reg(CfgWarnLevel, w);
      write_reg(CfgRearmLevel, r);
      case (kind)
        0, 4: begin
          write_reg(CfgCriticalSamp, $urandom_range(1, 6));
          write_reg(CfgWarnSamp, $urandom_range(1, 6));
          write_reg(CfgReminder, $urandom_range(0, 3000));
        end
        1: begin
          write_reg(CfgCriticalSamp, ((phase / 5) % 2 == 0) ? 32'd255 : 32'd254);
          write_reg(CfgWarnSamp, ((phase / 5) % 2 == 0) ? 32'd254 : 32'd0);
          write_reg(CfgReminder, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(CfgCriticalSamp, $urandom_range(0, 255));
          write_reg(CfgWarnSamp, $urandom_range(0, 255));
          write_reg(CfgReminder, $urandom);
        end
        default: begin
          write_reg(CfgCriticalSamp, 32'd1);
          write_reg(CfgWarnSamp, 32'd1);
          write_reg(CfgReminder, 32'd0);
        end
      endcase
      cfg_valid_i = 1'b0;
      settings_used++;

      phase_len  = (kind == 4) ? 16 : $urandom_range(60, 140);
      phase_done = 0;
      while (phase_done < phase_len && processed + skipped < RandItems) begin
        // pick the band: critical, low, gap or recovered
        lo = $urandom_range(0, 9);
        band_pick = (lo < 3) ? 0 : (lo < 7) ? 1 : (lo < 8) ? 2 : 3;
        lim = (band_pick == 0) ? 32'(shadow_cfg.critical_samples)
                               : 32'(shadow_cfg.warn_samples);
        if (band_pick >= 2) run_len = $urandom_range(1, 3);
        else if ((lim >= 200 || lim == 0) && $urandom_range(0, 2) == 0)
          run_len = $urandom_range(255, 266);
        else run_len = $urandom_range(1, (lim < 8) ? lim + 2 : 8);

        repeat (run_len) begin
          quiet_tail = (processed + skipped >= RandItems * 7 / 8);
          c = int'(shadow_cfg.critical_level);
          w = int'(shadow_cfg.warn_level);
          r = int'(shadow_cfg.rearm_level);
          lo = -1;
          hi = -1;
          case (band_pick)
            0: begin lo = 0; hi = c; end
            1: begin lo = c + 1; hi = w; end
            2: begin
              lo = ((w > c) ? w : c) + 1;
              hi = r - 1;
            end
            default: begin
              lo = ((w > c) ? w : c) + 1;
              if (r > lo) lo = r;
              hi = 4095;
            end
          endcase
          // noise: a sample anywhere, now and then
          if (lo > hi || $urandom_range(0, 15) == 0) smp = SampleBits'($urandom_range(0, 4095));
          else smp = SampleBits'($urandom_range(lo, hi));
          ok = ($urandom_range(0, 15) != 0);

          // advance the clock around the reminder interval, with rare jumps
          cap = (shadow_cfg.reminder_ms < 20000) ? shadow_cfg.reminder_ms / 2 + 20 : 1000;
          if ($urandom_range(0, 19) == 0) stamp = $urandom;
          else stamp = stamp + $urandom_range(0, cap);

          push_sample(smp, ok, stamp, 1'b0, none);
          phase_done++;
        end
      end
      phase++;
    end

    settle();

    $display("Run covered %0d processed and %0d ignored samples under %0d register settings",
             processed, skipped, settings_used);
    $display("Saw %0d power-off requests, %0d first prompts and %0d reminders",
             seen_power_off, seen_first, seen_reminder);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
